// ===== hdl/mpm_pkg.sv =====
package mpm_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned ENTRY_W = 31;
  localparam int unsigned EXP_W   = 64;
  localparam int unsigned MOD_W   = 31;

  // Defaults for the top-level parameters.
  localparam int unsigned EXP_BITS_DEF = 64;
  localparam int unsigned MOD_BITS_DEF = 31;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  // Stream packing: entries from the lowest bits up, then the exponent.
  localparam int unsigned S_DATA_W = 192;
  localparam int unsigned M_DATA_W = 128;
  localparam int unsigned EXP_LSB  = 4 * ENTRY_W;

  // One pass of a lane: a load, ENTRY_W shift steps, then a write-back.
  localparam int unsigned PASS_LEN = ENTRY_W + 2;
  localparam int unsigned CNT_W    = $clog2(PASS_LEN);

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

// ===== hdl/mpm_lane.sv =====
// Bit-serial modular multiply-accumulate: r = (x0 * y0 + x1 * y1) mod m.
// The multipliers are scanned from the top bit, one bit per step.
module mpm_lane #(
  parameter int unsigned MOD_BITS = mpm_pkg::MOD_BITS_DEF
) (
  input  logic                               clk_i,
  input  mpm_pkg::lane_ctl_t                 ctl_i,
  input  logic [mpm_pkg::ENTRY_W-1:0]        x0_i,
  input  logic [mpm_pkg::ENTRY_W-1:0]        x1_i,
  input  logic [MOD_BITS-1:0]                y0_i,
  input  logic [MOD_BITS-1:0]                y1_i,
  input  logic [MOD_BITS-1:0]                mod_i,
  input  logic [MOD_BITS+1:0]                mod2_i,
  input  logic [MOD_BITS+1:0]                mod3_i,
  output logic [MOD_BITS-1:0]                r_o
);

  logic [mpm_pkg::ENTRY_W-1:0] x0_q, x1_q;
  logic [MOD_BITS-1:0]         y0_q, y1_q;
  logic [MOD_BITS-1:0]         r_q, r_d;
  logic [MOD_BITS+1:0]         sum;
  logic [MOD_BITS+1:0]         mod1;
  logic [MOD_BITS+1:0]         sub;

  // The remainder stays below m and y0, y1 do not exceed m, so the sum is below 4m.
  always_comb begin
    mod1 = {2'b00, mod_i};
    sum  = {1'b0, r_q, 1'b0}
         + (x0_q[mpm_pkg::ENTRY_W-1] ? {2'b00, y0_q} : '0)
         + (x1_q[mpm_pkg::ENTRY_W-1] ? {2'b00, y1_q} : '0);
    if (sum >= mod3_i) begin
      sub = mod3_i;
    end else if (sum >= mod2_i) begin
      sub = mod2_i;
    end else if (sum >= mod1) begin
      sub = mod1;
    end else begin
      sub = '0;
    end
    r_d = MOD_BITS'(sum - sub);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x0_q <= x0_i;
      x1_q <= x1_i;
      y0_q <= y0_i;
      y1_q <= y1_i;
      r_q  <= '0;
    end else if (ctl_i.step) begin
      x0_q <= {x0_q[mpm_pkg::ENTRY_W-2:0], 1'b0};
      x1_q <= {x1_q[mpm_pkg::ENTRY_W-2:0], 1'b0};
      r_q  <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

// ===== hdl/matrix_power_mod_2x2_unit.sv =====
// 2x2 modular matrix power. An item carries a 2x2 matrix and an exponent; the
// result is the matrix raised to that power with every product entry reduced
// modulo the configured modulus (0 acts as 1), or the plain identity for a zero
// exponent. range_error flags an input entry that is not below the modulus.
// Eight bit-serial multiply-accumulate lanes compute the square of the base and
// the product of accumulator and base side by side, one multiplier bit a cycle.
// After acceptance, one pass of the lanes first reduces the input entries; then
// each exponent bit up to the highest set one takes one more pass (none for a
// zero exponent), each pass set by the 31-bit scan of the lanes. The result is
// then loaded into the output register. One item is in work at a time; a new
// one is taken while a result waits for output.
module matrix_power_mod_2x2_unit #(
  parameter int unsigned EXP_BITS = mpm_pkg::EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = mpm_pkg::MOD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mpm_pkg::MOD_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_00, entry_01, entry_10, entry_11, exponent, zero fill
  input  logic [mpm_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // power_00, power_01, power_10, power_11, zero fill
  output logic [mpm_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // range_error
  output logic                          m_axis_tuser
);

  localparam int unsigned EW = mpm_pkg::ENTRY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [mpm_pkg::CNT_W-1:0] CNT_LAST = mpm_pkg::CNT_W'(mpm_pkg::PASS_LEN - 1);

  logic [1:0]                 state_q, state_d;
  logic [mpm_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [MOD_BITS-1:0]        mod_q;
  logic [MOD_BITS-1:0]        m_q;
  logic [MOD_BITS+1:0]        m2_q, m3_q;
  logic [EXP_BITS-1:0]        e_q;
  logic [EW-1:0]              base_q [4];
  logic [MOD_BITS-1:0]        acc_q [4];
  logic                       err_q;
  logic                       out_valid_q;
  logic [4*EW-1:0]            out_pow_q;
  logic                       out_err_q;

  logic [MOD_BITS-1:0]        m_eff;
  logic [MOD_BITS+1:0]        m2_eff;
  logic                       accept;
  logic                       wb;
  logic                       finish;
  logic                       range_hit;
  logic [EW-1:0]              in_entry [4];
  mpm_pkg::lane_ctl_t         lane_ctl;

  logic [EW-1:0]              sq_x0 [4], sq_x1 [4], ac_x0 [4], ac_x1 [4];
  logic [MOD_BITS-1:0]        sq_y0 [4], sq_y1 [4], ac_y0 [4], ac_y1 [4];
  logic [MOD_BITS-1:0]        sq_r [4], ac_r [4];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_eff         = (mod_q == '0) ? MOD_BITS'(1) : mod_q;
  assign m2_eff        = {1'b0, m_eff, 1'b0};

  always_comb begin
    range_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      in_entry[k] = s_axis_tdata[k*EW +: EW];
      if (in_entry[k] >= EW'(m_eff)) begin
        range_hit = 1'b1;
      end
    end
  end

  assign lane_ctl = '{
    load: ((state_q == ST_PRE) || (state_q == ST_MUL)) && (cnt_q == '0),
    step: ((state_q == ST_PRE) || (state_q == ST_MUL)) && (cnt_q != '0) && (cnt_q != CNT_LAST)
  };
  assign wb            = ((state_q == ST_PRE) || (state_q == ST_MUL)) && (cnt_q == CNT_LAST);
  assign finish        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  // Lane (i, j) forms row i of the left operand against column j of the base.
  // During the reduction pass the square lanes compute raw_entry * 1 mod m.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        ac_x0[i*2+j] = EW'(acc_q[i*2]);
        ac_x1[i*2+j] = EW'(acc_q[i*2+1]);
        ac_y0[i*2+j] = base_q[j][MOD_BITS-1:0];
        ac_y1[i*2+j] = base_q[2+j][MOD_BITS-1:0];
        if (state_q == ST_PRE) begin
          sq_x0[i*2+j] = base_q[i*2+j];
          sq_x1[i*2+j] = '0;
          sq_y0[i*2+j] = MOD_BITS'(1);
          sq_y1[i*2+j] = '0;
        end else begin
          sq_x0[i*2+j] = base_q[i*2];
          sq_x1[i*2+j] = base_q[i*2+1];
          sq_y0[i*2+j] = base_q[j][MOD_BITS-1:0];
          sq_y1[i*2+j] = base_q[2+j][MOD_BITS-1:0];
        end
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    mpm_lane #(.MOD_BITS(MOD_BITS)) u_sq (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .x0_i   (sq_x0[g]),
      .x1_i   (sq_x1[g]),
      .y0_i   (sq_y0[g]),
      .y1_i   (sq_y1[g]),
      .mod_i  (m_q),
      .mod2_i (m2_q),
      .mod3_i (m3_q),
      .r_o    (sq_r[g])
    );
    mpm_lane #(.MOD_BITS(MOD_BITS)) u_ac (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .x0_i   (ac_x0[g]),
      .x1_i   (ac_x1[g]),
      .y0_i   (ac_y0[g]),
      .y1_i   (ac_y1[g]),
      .mod_i  (m_q),
      .mod2_i (m2_q),
      .mod3_i (m3_q),
      .r_o    (ac_r[g])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PRE;
          cnt_d   = '0;
        end
      end
      ST_PRE, ST_MUL: begin
        if (wb) begin
          cnt_d = '0;
          if (state_q == ST_PRE) begin
            state_d = (e_q == '0) ? ST_FIN : ST_MUL;
          end else begin
            state_d = ((e_q >> 1) == '0) ? ST_FIN : ST_MUL;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mod_q       <= MOD_BITS'(mpm_pkg::MOD_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i[MOD_BITS-1:0];
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        base_q[k] <= in_entry[k];
      end
      acc_q[0] <= MOD_BITS'(1);
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      acc_q[3] <= MOD_BITS'(1);
      e_q      <= s_axis_tdata[mpm_pkg::EXP_LSB +: EXP_BITS];
      err_q    <= range_hit;
      m_q      <= m_eff;
      m2_q     <= m2_eff;
      m3_q     <= m2_eff + {2'b00, m_eff};
    end else if (wb) begin
      for (int k = 0; k < 4; k++) begin
        base_q[k] <= EW'(sq_r[k]);
      end
      if (state_q == ST_MUL) begin
        if (e_q[0]) begin
          for (int k = 0; k < 4; k++) begin
            acc_q[k] <= ac_r[k];
          end
        end
        e_q <= e_q >> 1;
      end
    end
    if (finish) begin
      for (int k = 0; k < 4; k++) begin
        out_pow_q[k*EW +: EW] <= EW'(acc_q[k]);
      end
      out_err_q <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(mpm_pkg::M_DATA_W - 4*EW)'(0), out_pow_q};
  assign m_axis_tuser  = out_err_q;

endmodule

// ===== hdl/mpm_checker.sv =====
module mpm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [mpm_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic                          m_axis_tuser
);

  // A waiting result is neither withdrawn nor changed.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // Only one item is in work: input stalls right after an item is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  // A result never appears in the cycle after an item is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too soon after an item");

  // Handing off a result frees the input side in the same cycle.
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while the unit is still busy");

endmodule

bind matrix_power_mod_2x2_unit mpm_checker u_mpm_checker (.*);
